@@ rtl/core/lspa_pkg.sv @@
// Package for the LED strip pattern animator.
// Holds the payload structs, command and register codes and the control/status
// structs between controller and datapath. No dependencies.
`default_nettype none

package lspa_pkg;

  // Widths fixed by the item fields
  localparam int unsigned PIX_W = 6;
  localparam int unsigned COL_W = 8;
  localparam int unsigned CFG_W = 8;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_START = 2'd2,
    CMD_TICK  = 2'd3
  } lspa_cmd_t;

  // Display mode codes (code 3 starts like steady)
  localparam logic [1:0] MODE_STEADY = 2'd0;
  localparam logic [1:0] MODE_FLASH  = 2'd1;
  localparam logic [1:0] MODE_ROTATE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [1:0] CFG_ON_TIME      = 2'd1;
  localparam logic [1:0] CFG_OFF_TIME     = 2'd2;
  localparam logic [1:0] CFG_STEP_DELAY   = 2'd3;

  // Input beat
  typedef struct packed {
    lspa_cmd_t          command;
    logic [PIX_W-1:0]   entry_index;
    logic [COL_W-1:0]   red_in;
    logic [COL_W-1:0]   green_in;
    logic [COL_W-1:0]   blue_in;
    logic [COL_W-1:0]   dim_divisor;
  } lspa_in_t;

  // Result beat
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_index;
    logic [COL_W-1:0]   red_out;
    logic [COL_W-1:0]   green_out;
    logic [COL_W-1:0]   blue_out;
    logic               last_pixel;
  } lspa_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               div_go;       // capture load beat, start dividing
    logic               write;        // store divided colors
    logic               clear;        // drop all pattern entries
    logic               frame_go;     // begin a frame
    logic [PIX_W-1:0]   frame_offset; // entry shown at position 0
    logic               frame_dark;   // all-off frame
    logic               read_en;      // read and emit one pixel
  } lspa_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic               div_done;     // quotients ready
    logic               read_last;    // current read is the final pixel
  } lspa_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/lspa_div.sv @@
// Three-lane restoring divider: 8-bit colors by a shared 8-bit divisor,
// one quotient bit per cycle. Depends on lspa_pkg.
`default_nettype none

module lspa_div
  import lspa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [2:0][COL_W-1:0] dividend,
  input  wire logic [COL_W-1:0]      divisor,
  output logic      [2:0][COL_W-1:0] quotient,
  output logic                       done
);

  localparam int unsigned CNT_W = $clog2(COL_W);

  logic [COL_W-1:0]      dvs_r;
  logic [2:0][COL_W-1:0] rem_r, rem_nxt;
  logic [2:0][COL_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  act_r;
  logic                  done_r;

  // One trial subtraction per lane
  always_comb begin
    logic [COL_W+1:0] diff;
    for (int l = 0; l < 3; l++) begin
      diff = {1'b0, rem_r[l], quo_r[l][COL_W-1]} - {2'b00, dvs_r};
      if (diff[COL_W+1]) begin
        rem_nxt[l] = {rem_r[l][COL_W-2:0], quo_r[l][COL_W-1]};
        quo_nxt[l] = {quo_r[l][COL_W-2:0], 1'b0};
      end else begin
        rem_nxt[l] = diff[COL_W-1:0];
        quo_nxt[l] = {quo_r[l][COL_W-2:0], 1'b1};
      end
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    if (go) begin
      dvs_r <= (divisor == '0) ? COL_W'(1) : divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (act_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COL_W - 1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

@@ rtl/core/lspa_datapath.sv @@
// Datapath: pattern memory with per-entry valid bits, colour divider, frame
// address/pixel counters and the result register. Depends on lspa_pkg, lspa_div.
`default_nettype none

module lspa_datapath
  import lspa_pkg::*;
#(
  parameter int unsigned STRIP_LENGTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lspa_in_t   in_data,
  input  wire lspa_ctrl_t cmd,
  output lspa_stat_t      st,
  output logic            out_strobe,
  output lspa_out_t       out_data
);

  localparam int unsigned IW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(STRIP_LENGTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [3*COL_W-1:0]    mem [STRIP_LENGTH];
  logic [STRIP_LENGTH-1:0] vld_r;
  logic [IW-1:0]         wr_idx_r;
  logic [IW-1:0]         rd_idx_r;
  logic [PIX_W-1:0]      pix_r;
  logic                  dark_r;
  logic [3*COL_W-1:0]    rdata_r;
  logic                  rvld_r;
  logic [PIX_W-1:0]      opix_r;
  logic                  olast_r;
  logic                  ostb_r;
  logic [2:0][COL_W-1:0] quo;
  logic                  div_done;
  logic                  last_read;

  // Divide the three colors of a load beat
  lspa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend ({in_data.red_in, in_data.green_in, in_data.blue_in}),
    .divisor  (in_data.dim_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  // Hold the target entry of a load
  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      wr_idx_r <= in_data.entry_index[IW-1:0];
    end
  end

  // Pattern memory: write a divided entry, read one pixel a cycle
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_idx_r] <= quo;
    end
    if (cmd.read_en) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  // Valid bits: an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.write) begin
      vld_r[wr_idx_r] <= 1'b1;
    end
  end

  assign last_read = (pix_r == PIX_W'(STRIP_LENGTH - 1));

  // Frame counters and result register
  always_ff @(posedge clk) begin
    if (cmd.frame_go) begin
      rd_idx_r <= cmd.frame_offset[IW-1:0];
      pix_r    <= '0;
      dark_r   <= cmd.frame_dark;
    end else if (cmd.read_en) begin
      rd_idx_r <= next_idx(rd_idx_r);
      pix_r    <= pix_r + 1'b1;
    end
    if (cmd.read_en) begin
      rvld_r  <= vld_r[rd_idx_r];
      opix_r  <= pix_r;
      olast_r <= last_read;
    end
  end

  // Strobe one result beat per read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ostb_r <= 1'b0;
    end else begin
      ostb_r <= cmd.read_en;
    end
  end

  // Drive the result beat; dark frames and empty entries send zero
  always_comb begin
    logic [3*COL_W-1:0] rgb;
    rgb = (dark_r || !rvld_r) ? '0 : rdata_r;
    out_data.pixel_index = opix_r;
    out_data.red_out     = rgb[3*COL_W-1:2*COL_W];
    out_data.green_out   = rgb[2*COL_W-1:COL_W];
    out_data.blue_out    = rgb[COL_W-1:0];
    out_data.last_pixel  = olast_r;
  end

  assign out_strobe   = ostb_r;
  assign st.div_done  = div_done;
  assign st.read_last = cmd.read_en && last_read;

endmodule

`default_nettype wire

@@ rtl/core/lspa_ctrl.sv @@
// Controller: command decode, configuration registers, mode timing state
// and the sequencing state machine. Depends on lspa_pkg.
`default_nettype none

module lspa_ctrl
  import lspa_pkg::*;
#(
  parameter int unsigned STRIP_LENGTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire lspa_in_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire lspa_stat_t       st,
  output logic                  busy,
  output lspa_ctrl_t            cmd
);

  localparam int unsigned IW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(STRIP_LENGTH - 1)) ? '0 : i + 1'b1;
  endfunction

  state_t            state_r;
  logic [1:0]        mode_r;
  logic [CFG_W-1:0]  on_time_r, off_time_r, step_delay_r;
  logic              running_r;
  logic              lit_r;
  logic [IW-1:0]     rot_r;
  logic [CFG_W-1:0]  tick_r;

  logic              accept;
  logic              in_range;
  logic              is_flash, is_rotate, timed;
  logic [CFG_W-1:0]  tick_inc;
  logic [CFG_W-1:0]  limit_raw, limit;
  logic              fire;
  logic              do_load, do_start, do_tick;

  // Decode the accepted beat
  assign accept    = start && (state_r == S_IDLE);
  assign in_range  = {1'b0, in_data.entry_index} < (PIX_W + 1)'(STRIP_LENGTH);
  assign is_flash  = (mode_r == MODE_FLASH);
  assign is_rotate = (mode_r == MODE_ROTATE);
  assign timed     = running_r && (is_flash || is_rotate);
  assign do_load   = accept && (in_data.command == CMD_LOAD) && in_range;
  assign do_start  = accept && (in_data.command == CMD_START);
  assign do_tick   = accept && (in_data.command == CMD_TICK) && timed;

  // Phase limit, zero counts as one tick
  assign tick_inc  = tick_r + 1'b1;
  assign limit_raw = is_flash ? (lit_r ? on_time_r : off_time_r) : step_delay_r;
  assign limit     = (limit_raw == '0) ? CFG_W'(1) : limit_raw;
  assign fire      = (tick_inc >= limit);

  // Commands to the datapath
  always_comb begin
    cmd              = '0;
    cmd.div_go       = do_load;
    cmd.write        = (state_r == S_DIV) && st.div_done;
    cmd.clear        = accept && (in_data.command == CMD_CLEAR);
    cmd.frame_go     = do_start || (do_tick && fire);
    cmd.frame_offset = (do_tick && is_rotate) ? PIX_W'(rot_r) : '0;
    cmd.frame_dark   = do_tick && is_flash && lit_r;
    cmd.read_en      = (state_r == S_EMIT);
  end

  assign busy = (state_r != S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STEADY;
      on_time_r    <= '0;
      off_time_r   <= '0;
      step_delay_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISPLAY_MODE: mode_r       <= cfg_data[1:0];
        CFG_ON_TIME:      on_time_r    <= cfg_data;
        CFG_OFF_TIME:     off_time_r   <= cfg_data;
        CFG_STEP_DELAY:   step_delay_r <= cfg_data;
        default:          mode_r       <= mode_r;
      endcase
    end
  end

  // State machine and mode timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= 1'b0;
      lit_r     <= 1'b0;
      rot_r     <= '0;
      tick_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (do_load) begin
            state_r <= S_DIV;
          end else if (cmd.frame_go) begin
            state_r <= S_EMIT;
          end
          // Start the configured mode
          if (do_start) begin
            tick_r <= '0;
            if (is_flash) begin
              running_r <= 1'b1;
              lit_r     <= 1'b1;
            end else if (is_rotate) begin
              running_r <= 1'b1;
              rot_r     <= next_idx('0);
            end else begin
              running_r <= 1'b0;
            end
          end
          // Count a tick, advance the phase when it expires
          if (do_tick) begin
            tick_r <= fire ? '0 : tick_inc;
            if (fire && is_flash) begin
              lit_r <= !lit_r;
            end
            if (fire && is_rotate) begin
              rot_r <= next_idx(rot_r);
            end
          end
        end
        S_DIV: begin
          if (st.div_done) begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (st.read_last) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Rotation offset stays inside the strip
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(rot_r) < STRIP_LENGTH)
    else $error("rotation offset out of strip");

  // An in-range load goes to the divider
  assert property (@(posedge clk) disable iff (!rst_n)
    do_load |=> (state_r == S_DIV))
    else $error("load did not start division");

  // A frame request enters emission
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_go |=> (state_r == S_EMIT) && cmd.read_en)
    else $error("frame request not emitted");

  // A tick while stopped leaves the counter alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.command == CMD_TICK) && !running_r) |=> $stable(tick_r))
    else $error("tick counted while stopped");
`endif

endmodule

`default_nettype wire

@@ rtl/core/led_strip_pattern_animator.sv @@
// Top level of the LED strip pattern animator: joins controller and datapath.
// Depends on lspa_pkg, lspa_ctrl, lspa_datapath.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+------------------------------
//   input   | start, busy, in_data               | taken when start && !busy
//   result  | out_strobe, out_data               | one cycle per beat, no stall
//   config  | cfg_we, cfg_index, cfg_data        | written when cfg_we is high
//
// A load runs its 8-bit quotients through the shared divider, then does the memory
// write; clear and non-firing ticks never raise busy.
// A frame does one pattern memory read per pixel, with each result beat
// registered and sent in the cycle after its read.
// busy is high from the cycle after acceptance through the final read or write.
// Reset is synchronous; it clears the valid bits, so the pattern reads as zero.
`default_nettype none

module led_strip_pattern_animator
  import lspa_pkg::*;
#(
  parameter int unsigned STRIP_LENGTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire lspa_in_t         in_data,
  output logic                  out_strobe,
  output lspa_out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  lspa_ctrl_t cmd;
  lspa_stat_t st;

  // Sequencing and mode timing
  lspa_ctrl #(
    .STRIP_LENGTH (STRIP_LENGTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Pattern storage and pixel output
  lspa_datapath #(
    .STRIP_LENGTH (STRIP_LENGTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .st         (st),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ tb/tb_led_strip_pattern_animator.sv @@
// Self-checking bench for led_strip_pattern_animator: drives command beats, predicts
// each pixel beat of every frame and compares them in order as they appear.
// Depends on lspa_pkg and the animator RTL; reads no files.
module tb_led_strip_pattern_animator;
  import lspa_pkg::*;

  localparam int unsigned LEDS = 16;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 20;

  // Tracks pattern, timers and mode; holds the pixel beats still due
  class strip_frame_tracker;
    localparam int unsigned SHOWN_LIMIT = 10;
    int unsigned leds;
    logic [23:0] pattern [64];
    bit running;
    bit lit;
    int unsigned rot_offset;
    logic [7:0] ticks;
    logic [1:0] mode;
    logic [7:0] on_ticks;
    logic [7:0] off_ticks;
    logic [7:0] step_ticks;
    lspa_out_t pixels_due [$];
    int unsigned mismatches;
    int unsigned pixels_checked;
    int unsigned frames_due;
    int unsigned live_beats;
    int unsigned dropped_loads;
    int unsigned reg_writes;
    int unsigned cmd_seen [4];

    function new(int unsigned n);
      leds = n;
      foreach (pattern[i]) pattern[i] = '0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      running = 1'b0;
      lit = 1'b0;
      rot_offset = 0;
      ticks = '0;
      mode = MODE_STEADY;
      on_ticks = '0;
      off_ticks = '0;
      step_ticks = '0;
      mismatches = 0;
      pixels_checked = 0;
      frames_due = 0;
      live_beats = 0;
      dropped_loads = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      reg_writes++;
      case (idx)
        CFG_DISPLAY_MODE: mode = val[1:0];
        CFG_ON_TIME:      on_ticks = val;
        CFG_OFF_TIME:     off_ticks = val;
        CFG_STEP_DELAY:   step_ticks = val;
        default: ;
      endcase
    endfunction

    // Queue one frame starting at pattern entry first; dark sends all-off pixels
    function void queue_frame(int unsigned first, bit dark);
      int unsigned n;
      logic [23:0] rgb;
      lspa_out_t px;
      n = first % leds;
      frames_due++;
      for (int unsigned i = 0; i < leds; i++) begin
        rgb = dark ? 24'd0 : pattern[n];
        px.pixel_index = 6'(i);
        px.red_out = rgb[23:16];
        px.green_out = rgb[15:8];
        px.blue_out = rgb[7:0];
        px.last_pixel = (i == leds - 1);
        pixels_due.push_back(px);
        n = (n + 1 >= leds) ? 0 : n + 1;
      end
    endfunction

    function void note_beat(lspa_in_t b);
      int unsigned divisor;
      int unsigned limit;
      cmd_seen[b.command]++;
      case (b.command)
        CMD_LOAD: begin
          // store divided colors; entries past the strip end are dropped
          if (b.entry_index < leds) begin
            divisor = (b.dim_divisor == 0) ? 1 : b.dim_divisor;
            pattern[b.entry_index] = {8'(b.red_in / divisor), 8'(b.green_in / divisor),
                                      8'(b.blue_in / divisor)};
            live_beats++;
          end else begin
            dropped_loads++;
          end
        end
        CMD_CLEAR: begin
          foreach (pattern[i]) pattern[i] = '0;
          live_beats++;
        end
        CMD_START: begin
          live_beats++;
          ticks = '0;
          if (mode == MODE_FLASH) begin
            running = 1'b1;
            lit = 1'b1;
          end else if (mode == MODE_ROTATE) begin
            running = 1'b1;
            rot_offset = (leds > 1) ? 1 : 0;
          end else begin
            running = 1'b0;
          end
          queue_frame(0, 1'b0);
        end
        CMD_TICK: begin
          // advance the timer of the current mode; steady or spare mode holds
          if (running && (mode == MODE_FLASH || mode == MODE_ROTATE)) begin
            live_beats++;
            if (mode == MODE_FLASH) limit = lit ? on_ticks : off_ticks;
            else limit = step_ticks;
            if (limit == 0) limit = 1;
            ticks = ticks + 8'd1;
            if (ticks >= limit) begin
              ticks = '0;
              if (mode == MODE_FLASH) begin
                queue_frame(0, lit);
                lit = !lit;
              end else begin
                queue_frame(rot_offset, 1'b0);
                rot_offset = (rot_offset + 1 >= leds) ? 0 : rot_offset + 1;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(lspa_out_t got);
      lspa_out_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_LIMIT)
          $display("%0t: unexpected pixel beat idx %0d rgb %02h %02h %02h last %0b", $time,
                   got.pixel_index, got.red_out, got.green_out, got.blue_out, got.last_pixel);
        return;
      end
      want = pixels_due.pop_front();
      pixels_checked++;
      if (got.pixel_index !== want.pixel_index || got.red_out !== want.red_out ||
          got.green_out !== want.green_out || got.blue_out !== want.blue_out ||
          got.last_pixel !== want.last_pixel) begin
        mismatches++;
        if (mismatches <= SHOWN_LIMIT)
          $display("%0t: pixel mismatch, expected idx %0d rgb %02h %02h %02h last %0b, got idx %0d rgb %02h %02h %02h last %0b",
                   $time, want.pixel_index, want.red_out, want.green_out, want.blue_out,
                   want.last_pixel, got.pixel_index, got.red_out, got.green_out, got.blue_out,
                   got.last_pixel);
      end
    endfunction

    function int unsigned outstanding();
      return pixels_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  lspa_in_t in_data;
  logic out_strobe;
  lspa_out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int idle_pct;
  int idle_plan [3] = '{0, 47, 14};
  logic [1:0] mode_plan [8] = '{MODE_FLASH, MODE_ROTATE, MODE_STEADY, MODE_ROTATE,
                                MODE_FLASH, MODE_SPARE, MODE_ROTATE, MODE_FLASH};
  strip_frame_tracker frames = new(LEDS);

  led_strip_pattern_animator #(
    .STRIP_LENGTH(LEDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe handshakes with the values present before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) frames.check_pixel(out_data);
      if (start && !busy) frames.note_beat(in_data);
      if (cfg_we) frames.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic lspa_in_t cmd_beat(lspa_cmd_t c, int unsigned idx, int unsigned r,
                                        int unsigned g, int unsigned bl, int unsigned dv);
    lspa_in_t b;
    b.command = c;
    b.entry_index = 6'(idx);
    b.red_in = 8'(r);
    b.green_in = 8'(g);
    b.blue_in = 8'(bl);
    b.dim_divisor = 8'(dv);
    return b;
  endfunction

  // Random payload around a fixed command; most loads land inside the strip
  function automatic lspa_in_t filled(lspa_cmd_t c);
    lspa_in_t b;
    b.command = c;
    b.entry_index = ($urandom_range(9) < 8) ? 6'($urandom_range(LEDS - 1))
                                            : 6'($urandom_range(63));
    b.red_in = 8'($urandom);
    b.green_in = 8'($urandom);
    b.blue_in = 8'($urandom);
    case ($urandom_range(3))
      0: b.dim_divisor = 8'd0;
      1: b.dim_divisor = 8'd1;
      2: b.dim_divisor = 8'($urandom_range(2, 9));
      default: b.dim_divisor = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic lspa_in_t random_beat();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return filled(CMD_LOAD);
    if (r < 40) return filled(CMD_CLEAR);
    if (r < 50) return filled(CMD_START);
    return filled(CMD_TICK);
  endfunction

  // Mostly short timers so frames come often, now and then a long one
  function automatic logic [7:0] pick_delay();
    return ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
  endfunction

  // Present one beat, after an optional idle gap, and hold it until taken
  task automatic send_beat(input lspa_in_t b);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 12) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every predicted pixel has arrived and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (frames.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [1:0] m, input logic [7:0] on_t,
                            input logic [7:0] off_t, input logic [7:0] step_t);
    put_reg(CFG_DISPLAY_MODE, {6'd0, m});
    put_reg(CFG_ON_TIME, on_t);
    put_reg(CFG_OFF_TIME, off_t);
    put_reg(CFG_STEP_DELAY, step_t);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned wait_count;
    int p;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DISPLAY_MODE;
    cfg_data <= '0;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern gives an all-zero frame; a tick while stopped does nothing
    send_beat(cmd_beat(CMD_START, 0, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_TICK, 0, 0, 0, 0, 0));
    // loads across the divisor range, two of them past the strip end
    send_beat(cmd_beat(CMD_LOAD, 0, 255, 255, 255, 0));
    send_beat(cmd_beat(CMD_LOAD, LEDS - 1, 255, 128, 1, 1));
    send_beat(cmd_beat(CMD_LOAD, 7, 255, 200, 100, 255));
    send_beat(cmd_beat(CMD_LOAD, 3, 17, 34, 51, 7));
    send_beat(cmd_beat(CMD_LOAD, LEDS, 1, 2, 3, 1));
    send_beat(cmd_beat(CMD_LOAD, 63, 9, 9, 9, 1));
    send_beat(cmd_beat(CMD_LOAD, 8, 8'hAA, 8'h55, 8'hFF, 2));
    send_beat(cmd_beat(CMD_START, 0, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_CLEAR, 0, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_START, 0, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_LOAD, 1, 200, 100, 50, 3));
    // spare mode code starts like steady
    drain();
    write_regs(MODE_SPARE, 8'd0, 8'd0, 8'd0);
    send_beat(cmd_beat(CMD_START, 0, 0, 0, 0, 0));
    send_beat(cmd_beat(CMD_TICK, 0, 0, 0, 0, 0));
    // flashing with zero times: each tick flips between dark and lit
    drain();
    write_regs(MODE_FLASH, 8'd0, 8'd0, 8'd0);
    send_beat(cmd_beat(CMD_START, 0, 0, 0, 0, 0));
    repeat (3) send_beat(cmd_beat(CMD_TICK, 0, 0, 0, 0, 0));
    // rotating with zero delay: each tick steps the offset
    drain();
    write_regs(MODE_ROTATE, 8'd0, 8'd0, 8'd0);
    send_beat(cmd_beat(CMD_START, 0, 0, 0, 0, 0));
    repeat (3) send_beat(cmd_beat(CMD_TICK, 0, 0, 0, 0, 0));
    // change the mode under a running timer
    drain();
    write_regs(MODE_STEADY, 8'd0, 8'd0, 8'd0);
    send_beat(cmd_beat(CMD_TICK, 0, 0, 0, 0, 0));
    drain();
    write_regs(MODE_FLASH, 8'd2, 8'd255, 8'd0);
    send_beat(cmd_beat(CMD_TICK, 0, 0, 0, 0, 0));

    // longer timers: full lit and dark phases, then two rotation steps
    drain();
    write_regs(MODE_FLASH, 8'd5, 8'd3, 8'd0);
    send_beat(filled(CMD_START));
    repeat (12) send_beat(filled(CMD_TICK));
    drain();
    write_regs(MODE_ROTATE, 8'd0, 8'd255, 8'd4);
    send_beat(filled(CMD_START));
    repeat (9) send_beat(filled(CMD_TICK));

    // random phases, each with its own settings and idle rate
    p = 0;
    while (p < 7) begin
      drain();
      idle_pct = idle_plan[p % 3];
      write_regs(mode_plan[p % 8], pick_delay(), pick_delay(), pick_delay());
      repeat (32) send_beat(random_beat());
      p++;
    end

    // let the last frames out, then settle
    idle_pct = 0;
    start <= 1'b0;
    wait_count = 0;
    do begin
      @(posedge clk);
      wait_count++;
    end while (frames.outstanding() != 0 && wait_count < 5000);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d loads (%0d past the strip end), %0d clears, %0d starts, %0d ticks, %0d register writes",
             frames.cmd_seen[CMD_LOAD], frames.dropped_loads, frames.cmd_seen[CMD_CLEAR],
             frames.cmd_seen[CMD_START], frames.cmd_seen[CMD_TICK], frames.reg_writes);
    $display("%0d frames predicted, %0d pixel beats checked, %0d mismatches, %0d beats never seen",
             frames.frames_due, frames.pixels_checked, frames.mismatches, frames.outstanding());
    if (frames.mismatches == 0 && frames.outstanding() == 0) begin
      $display("tb_led_strip_pattern_animator: clean");
    end else begin
      $display("tb_led_strip_pattern_animator: errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #2_000_000;
    $display("watchdog expired with %0d pixel beats pending", frames.outstanding());
    $display("tb_led_strip_pattern_animator: errors");
    $finish;
  end

endmodule

@@ led_strip_pattern_animator.f @@
rtl/core/lspa_pkg.sv
rtl/core/lspa_div.sv
rtl/core/lspa_datapath.sv
rtl/core/lspa_ctrl.sv
rtl/core/led_strip_pattern_animator.sv
tb/tb_led_strip_pattern_animator.sv
